// ===== sv/bncs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bncs_pkg;

  localparam int CoordW    = 24;
  localparam int DiffW     = CoordW + 1;
  localparam int MagW      = CoordW;
  localparam int SqW       = 2 * MagW;
  localparam int D2W       = SqW + 2;
  localparam int RootW     = D2W / 2;
  localparam int RemW      = RootW + 2;
  localparam int SqrtSteps = RootW;
  localparam int Axes      = 3;
  localparam int IdxW      = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [Axes-1:0]        vec3_t;
  typedef logic [MagW-1:0]          mag_t;
  typedef mag_t [Axes-1:0]          mag3_t;
  typedef logic [IdxW-1:0]          idx_t;
  typedef logic [D2W-1:0]           d2_t;
  typedef logic [RootW-1:0]         root_t;

  typedef struct packed {
    idx_t   idx;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } corner_tag_t;

endpackage

`default_nettype wire

// ===== sv/bncs_corner.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bncs_corner (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_vld,
  output logic                      in_rdy,
  input  bncs_pkg::vec3_t           in_pnt,
  input  bncs_pkg::vec3_t           in_lo,
  input  bncs_pkg::vec3_t           in_hi,
  output logic                      out_vld,
  input  wire                       out_rdy,
  output bncs_pkg::corner_tag_t     out_tag,
  output bncs_pkg::mag3_t           out_mag
);
  import bncs_pkg::*;

  logic en1, en2, en3;

  logic                 s1_vld_r;
  logic [DiffW-1:0]     s1_dlo_r [Axes];
  logic [DiffW-1:0]     s1_dhi_r [Axes];
  vec3_t                s1_lo_r, s1_hi_r;
  logic [DiffW-1:0]     dlo_nxt [Axes];
  logic [DiffW-1:0]     dhi_nxt [Axes];

  logic                 s2_vld_r;
  mag3_t                s2_mlo_r, s2_mhi_r;
  vec3_t                s2_lo_r, s2_hi_r;
  mag3_t                mlo_nxt, mhi_nxt;
  logic [DiffW-1:0]     neg_lo, neg_hi;

  logic                 s3_vld_r;
  corner_tag_t          s3_tag_r;
  mag3_t                s3_mag_r;
  logic [Axes-1:0]      sel_nxt;
  vec3_t                c_nxt;
  mag3_t                m_nxt;

  assign en3    = !s3_vld_r || out_rdy;
  assign en2    = !s2_vld_r || en3;
  assign en1    = !s1_vld_r || en2;
  assign in_rdy = en1;

  always_comb begin
    for (int k = 0; k < Axes; k++) begin
      dlo_nxt[k] = {in_pnt[k][CoordW-1], in_pnt[k]} - {in_lo[k][CoordW-1], in_lo[k]};
      dhi_nxt[k] = {in_pnt[k][CoordW-1], in_pnt[k]} - {in_hi[k][CoordW-1], in_hi[k]};
    end
  end

  always_comb begin
    neg_lo = '0;
    neg_hi = '0;
    for (int k = 0; k < Axes; k++) begin
      neg_lo     = ~s1_dlo_r[k] + DiffW'(1);
      neg_hi     = ~s1_dhi_r[k] + DiffW'(1);
      mlo_nxt[k] = s1_dlo_r[k][DiffW-1] ? neg_lo[MagW-1:0] : s1_dlo_r[k][MagW-1:0];
      mhi_nxt[k] = s1_dhi_r[k][DiffW-1] ? neg_hi[MagW-1:0] : s1_dhi_r[k][MagW-1:0];
    end
  end

  // take the upper bound on a tie
  always_comb begin
    for (int k = 0; k < Axes; k++) begin
      sel_nxt[k] = (s2_mhi_r[k] <= s2_mlo_r[k]);
      c_nxt[k]   = sel_nxt[k] ? s2_hi_r[k] : s2_lo_r[k];
      m_nxt[k]   = sel_nxt[k] ? s2_mhi_r[k] : s2_mlo_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (en1) s1_vld_r <= in_vld;
      if (en2) s2_vld_r <= s1_vld_r;
      if (en3) s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_vld) begin
      s1_dlo_r <= dlo_nxt;
      s1_dhi_r <= dhi_nxt;
      s1_lo_r  <= in_lo;
      s1_hi_r  <= in_hi;
    end
    if (en2 && s1_vld_r) begin
      s2_mlo_r <= mlo_nxt;
      s2_mhi_r <= mhi_nxt;
      s2_lo_r  <= s1_lo_r;
      s2_hi_r  <= s1_hi_r;
    end
    if (en3 && s2_vld_r) begin
      s3_tag_r.idx <= {sel_nxt[0], sel_nxt[1], sel_nxt[2]};
      s3_tag_r.cx  <= c_nxt[0];
      s3_tag_r.cy  <= c_nxt[1];
      s3_tag_r.cz  <= c_nxt[2];
      s3_mag_r     <= m_nxt;
    end
  end

  assign out_vld = s3_vld_r;
  assign out_tag = s3_tag_r;
  assign out_mag = s3_mag_r;

  a_corner_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r && !out_rdy |=> s3_vld_r && $stable(s3_mag_r) && $stable(s3_tag_r))
    else $error("corner stage lost a stalled word");

endmodule

`default_nettype wire

// ===== sv/bncs_sqdist.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bncs_sqdist (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_vld,
  output logic                      in_rdy,
  input  bncs_pkg::corner_tag_t     in_tag,
  input  bncs_pkg::mag3_t           in_mag,
  output logic                      out_vld,
  input  wire                       out_rdy,
  output bncs_pkg::corner_tag_t     out_tag,
  output bncs_pkg::d2_t             out_d2
);
  import bncs_pkg::*;

  logic              en4, en5;
  logic              s4_vld_r;
  logic [SqW-1:0]    s4_sq_r [Axes];
  logic [SqW-1:0]    sq_nxt [Axes];
  corner_tag_t       s4_tag_r;
  logic              s5_vld_r;
  d2_t               s5_d2_r;
  d2_t               d2_nxt;
  corner_tag_t       s5_tag_r;

  assign en5    = !s5_vld_r || out_rdy;
  assign en4    = !s4_vld_r || en5;
  assign in_rdy = en4;

  always_comb begin
    for (int k = 0; k < Axes; k++) begin
      sq_nxt[k] = in_mag[k] * in_mag[k];
    end
  end

  assign d2_nxt = D2W'(s4_sq_r[0]) + D2W'(s4_sq_r[1]) + D2W'(s4_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      if (en4) s4_vld_r <= in_vld;
      if (en5) s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && in_vld) begin
      s4_sq_r  <= sq_nxt;
      s4_tag_r <= in_tag;
    end
    if (en5 && s4_vld_r) begin
      s5_d2_r  <= d2_nxt;
      s5_tag_r <= s4_tag_r;
    end
  end

  assign out_vld = s5_vld_r;
  assign out_tag = s5_tag_r;
  assign out_d2  = s5_d2_r;

  a_d2_range: assert property (@(posedge clk) disable iff (!rst_n)
    s5_vld_r |-> s5_d2_r[D2W-1:D2W-2] != 2'b11)
    else $error("squared distance above three squared axis spans");

endmodule

`default_nettype wire

// ===== sv/bncs_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bncs_isqrt (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_vld,
  output logic                      in_rdy,
  input  bncs_pkg::corner_tag_t     in_tag,
  input  bncs_pkg::d2_t             in_d2,
  output logic                      out_vld,
  input  wire                       out_rdy,
  output bncs_pkg::corner_tag_t     out_tag,
  output bncs_pkg::root_t           out_root
);
  import bncs_pkg::*;

  logic [SqrtSteps-1:0] vld_r;
  logic [SqrtSteps:0]   en;
  logic [RemW-1:0]      rem_r  [SqrtSteps];
  root_t                root_r [SqrtSteps];
  d2_t                  rad_r  [SqrtSteps];
  corner_tag_t          tag_r  [SqrtSteps];

  assign en[SqrtSteps] = out_rdy;
  assign in_rdy        = en[0];

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
    logic            prv_vld;
    logic [RemW-1:0] prv_rem;
    root_t           prv_root;
    d2_t             prv_rad;
    corner_tag_t     prv_tag;
    logic [RemW+1:0] rem_sh;
    logic [RemW+1:0] trial;
    logic [RemW+1:0] diff;
    logic            ge;
    logic [RemW-1:0] rem_nxt;
    root_t           root_nxt;
    d2_t             rad_nxt;

    if (i == 0) begin : g_first
      assign prv_vld  = in_vld;
      assign prv_rem  = '0;
      assign prv_root = '0;
      assign prv_rad  = in_d2;
      assign prv_tag  = in_tag;
    end else begin : g_next
      assign prv_vld  = vld_r[i-1];
      assign prv_rem  = rem_r[i-1];
      assign prv_root = root_r[i-1];
      assign prv_rad  = rad_r[i-1];
      assign prv_tag  = tag_r[i-1];
    end

    assign en[i]    = !vld_r[i] || en[i+1];
    assign rem_sh   = {prv_rem, prv_rad[D2W-1 -: 2]};
    assign trial    = {{(RemW-RootW){1'b0}}, prv_root, 2'b01};
    assign ge       = (rem_sh >= trial);
    assign diff     = rem_sh - trial;
    assign rem_nxt  = ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
    assign root_nxt = {prv_root[RootW-2:0], ge};
    assign rad_nxt  = {prv_rad[D2W-3:0], 2'b00};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en[i+1] || !vld_r[i]) begin
        vld_r[i] <= prv_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i] && prv_vld) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        rad_r[i]  <= rad_nxt;
        tag_r[i]  <= prv_tag;
      end
    end
  end

  assign out_vld  = vld_r[SqrtSteps-1];
  assign out_tag  = tag_r[SqrtSteps-1];
  assign out_root = root_r[SqrtSteps-1];

  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SqrtSteps-1] |->
      rem_r[SqrtSteps-1] <= {{(RemW-RootW-1){1'b0}}, root_r[SqrtSteps-1], 1'b0})
    else $error("root remainder exceeds twice the root");

endmodule

`default_nettype wire

// ===== sv/box_nearest_corner_select.sv =====
// Nearest box corner: each word carries a query point and the two bounds of an
// axis-aligned box in signed Q12.12 and returns the index of the nearest of the
// eight corners (bit 2 upper x, bit 1 upper y, bit 0 upper z; ties go to the
// upper bound, i.e. the highest index), the corner's coordinates and the floor
// of its Euclidean distance in unsigned Q13.12. One word enters per cycle while
// the pipeline is not stalled: three stages pick the nearer bound per axis, two
// square and sum, and the 25-bit root is resolved one bit per stage over 25
// stages. Every stage holds its own valid bit, so bubbles close up when the
// output stalls and in_ready drops only when every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module box_nearest_corner_select (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  signed [23:0]            in_point_x,
  input  wire  signed [23:0]            in_point_y,
  input  wire  signed [23:0]            in_point_z,
  input  wire  signed [23:0]            in_box_min_x,
  input  wire  signed [23:0]            in_box_min_y,
  input  wire  signed [23:0]            in_box_min_z,
  input  wire  signed [23:0]            in_box_max_x,
  input  wire  signed [23:0]            in_box_max_y,
  input  wire  signed [23:0]            in_box_max_z,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [2:0]                    out_corner_index,
  output logic signed [23:0]            out_corner_x,
  output logic signed [23:0]            out_corner_y,
  output logic signed [23:0]            out_corner_z,
  output logic [24:0]                   out_distance
);
  import bncs_pkg::*;

  vec3_t       pnt, lo, hi;
  logic        c_vld, c_rdy;
  corner_tag_t c_tag;
  mag3_t       c_mag;
  logic        d_vld, d_rdy;
  corner_tag_t d_tag;
  d2_t         d_d2;
  corner_tag_t r_tag;
  root_t       r_root;

  assign pnt = {in_point_z, in_point_y, in_point_x};
  assign lo  = {in_box_min_z, in_box_min_y, in_box_min_x};
  assign hi  = {in_box_max_z, in_box_max_y, in_box_max_x};

  bncs_corner u_corner (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_valid),
    .in_rdy  (in_ready),
    .in_pnt  (pnt),
    .in_lo   (lo),
    .in_hi   (hi),
    .out_vld (c_vld),
    .out_rdy (c_rdy),
    .out_tag (c_tag),
    .out_mag (c_mag)
  );

  bncs_sqdist u_sqdist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (c_vld),
    .in_rdy  (c_rdy),
    .in_tag  (c_tag),
    .in_mag  (c_mag),
    .out_vld (d_vld),
    .out_rdy (d_rdy),
    .out_tag (d_tag),
    .out_d2  (d_d2)
  );

  bncs_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d_vld),
    .in_rdy   (d_rdy),
    .in_tag   (d_tag),
    .in_d2    (d_d2),
    .out_vld  (out_valid),
    .out_rdy  (out_ready),
    .out_tag  (r_tag),
    .out_root (r_root)
  );

  assign out_corner_index = r_tag.idx;
  assign out_corner_x     = r_tag.cx;
  assign out_corner_y     = r_tag.cy;
  assign out_corner_z     = r_tag.cz;
  assign out_distance     = r_root;

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off while the pipeline can still drain");

endmodule

`default_nettype wire

// ===== test/box_nearest_corner_select_test.sv =====
`timescale 1ns / 1ps

module box_nearest_corner_select_test;
  import bncs_pkg::*;

  localparam int CMin = -8388608;
  localparam int CMax = 8388607;
  localparam int Latency = 30;
  localparam int HoldCycles = 250;

  typedef struct packed {
    vec3_t pt;
    vec3_t lo;
    vec3_t hi;
  } box_query_t;

  typedef struct packed {
    idx_t  idx;
    vec3_t corner;
    root_t span;
  } corner_hit_t;

  typedef struct {
    box_query_t  q;
    bit          typed;
    corner_hit_t want;
  } probe_row_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  coord_t in_point_z = '0;
  coord_t in_box_min_x = '0;
  coord_t in_box_min_y = '0;
  coord_t in_box_min_z = '0;
  coord_t in_box_max_x = '0;
  coord_t in_box_max_y = '0;
  coord_t in_box_max_z = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  idx_t   out_corner_index;
  coord_t out_corner_x;
  coord_t out_corner_y;
  coord_t out_corner_z;
  root_t  out_distance;

  corner_hit_t expected_hits [$];
  probe_row_t  probe_rows [$];
  int          mismatches = 0;
  bit          hold_off = 1'b0;
  string       axis_field [3] = '{"corner_x", "corner_y", "corner_z"};

  box_nearest_corner_select dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_z       (in_point_z),
    .in_box_min_x     (in_box_min_x),
    .in_box_min_y     (in_box_min_y),
    .in_box_min_z     (in_box_min_z),
    .in_box_max_x     (in_box_max_x),
    .in_box_max_y     (in_box_max_y),
    .in_box_max_z     (in_box_max_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_corner_index (out_corner_index),
    .out_corner_x     (out_corner_x),
    .out_corner_y     (out_corner_y),
    .out_corner_z     (out_corner_z),
    .out_distance     (out_distance)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic vec3_t vec(coord_t x, coord_t y, coord_t z);
    vec3_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    return v;
  endfunction

  function automatic root_t floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = RootW - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return root_t'(r);
  endfunction

  // scan high index to low, replace only on strictly smaller distance
  function automatic corner_hit_t nearest_corner(box_query_t q);
    corner_hit_t     hit;
    coord_t          c [3];
    longint          dd;
    longint unsigned d2;
    longint unsigned best;
    hit = '0;
    best = 0;
    for (int k = 7; k >= 0; k--) begin
      d2 = 0;
      for (int a = 0; a < 3; a++) begin
        c[a] = ((k >> (2 - a)) & 1) ? q.hi[a] : q.lo[a];
        dd = longint'($signed(q.pt[a])) - longint'($signed(c[a]));
        d2 += longint'(dd * dd);
      end
      if (k == 7 || d2 < best) begin
        best = d2;
        hit.idx = idx_t'(k);
        hit.corner = vec(c[0], c[1], c[2]);
      end
    end
    hit.span = floor_root(best);
    return hit;
  endfunction

  function automatic coord_t pick_coord(int style);
    case (style)
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(0, 16)) - 8);
      2: begin
        case ($urandom_range(0, 4))
          0: return coord_t'(CMin);
          1: return coord_t'(CMax);
          2: return '0;
          3: return '1;
          default: return coord_t'($urandom);
        endcase
      end
      default: return coord_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic box_query_t random_query();
    box_query_t  q;
    int          style;
    int unsigned shape;
    int          mid;
    int          half;
    coord_t      t;
    style = $urandom_range(0, 3);
    for (int a = 0; a < 3; a++) begin
      q.pt[a] = pick_coord(style);
      q.lo[a] = pick_coord(style);
      q.hi[a] = pick_coord(style);
      shape = $urandom_range(0, 9);
      if (shape < 5 && $signed(q.lo[a]) > $signed(q.hi[a])) begin
        t = q.lo[a];
        q.lo[a] = q.hi[a];
        q.hi[a] = t;
      end else if (shape == 5) begin
        q.hi[a] = q.lo[a];
      end else if (shape == 6) begin
        mid = int'($urandom_range(0, 1 << 22)) - (1 << 21);
        half = $urandom_range(0, 1 << 20);
        q.lo[a] = coord_t'(mid - half);
        q.hi[a] = coord_t'(mid + half);
        q.pt[a] = coord_t'(mid);
      end else if (shape == 7) begin
        q.pt[a] = $urandom_range(0, 1) ? q.lo[a] : q.hi[a];
      end
    end
    return q;
  endfunction

  task automatic add_probe(vec3_t pt, vec3_t lo, vec3_t hi, bit typed = 1'b0,
                           int idx = 0, vec3_t c = '0, int span = 0);
    probe_row_t row;
    row.q.pt = pt;
    row.q.lo = lo;
    row.q.hi = hi;
    row.typed = typed;
    row.want.idx = idx_t'(idx);
    row.want.corner = c;
    row.want.span = root_t'(span);
    probe_rows.push_back(row);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic send_word(box_query_t q, corner_hit_t want, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= q.pt[0];
    in_point_y <= q.pt[1];
    in_point_z <= q.pt[2];
    in_box_min_x <= q.lo[0];
    in_box_min_y <= q.lo[1];
    in_box_min_z <= q.lo[2];
    in_box_max_x <= q.hi[0];
    in_box_max_y <= q.hi[1];
    in_box_max_z <= q.hi[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_hits.push_back(want);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  initial begin : feed
    vec3_t       corner;
    corner_hit_t want;
    box_query_t  q;
    int          gap;
    add_probe(vec(0, 0, 0), vec(0, 0, 0), vec(0, 0, 0), 1, 7, vec(0, 0, 0), 0);
    add_probe(vec(4096, 0, 0), vec(0, 0, 0), vec(0, 0, 0), 1, 7, vec(0, 0, 0), 4096);
    add_probe(vec(0, 0, 0), vec(-4096, -4096, -4096), vec(4096, 4096, 4096),
              1, 7, vec(4096, 4096, 4096), 7094);
    add_probe(vec(0, -4096, -4096), vec(-4096, -4096, -4096), vec(4096, 4096, 4096),
              1, 4, vec(4096, -4096, -4096), 4096);
    for (int k = 0; k < 8; k++) begin
      corner = vec((k & 4) ? CMax : CMin, (k & 2) ? CMax : CMin, (k & 1) ? CMax : CMin);
      add_probe(corner, vec(CMin, CMin, CMin), vec(CMax, CMax, CMax), 1, k, corner, 0);
    end
    add_probe(vec(CMin, CMin, CMin), vec(CMin, CMin, CMin), vec(CMin, CMin, CMin),
              1, 7, vec(CMin, CMin, CMin), 0);
    add_probe(vec(4096, 0, 0), vec(4096, 0, 0), vec(-4096, 0, 0), 1, 3, vec(4096, 0, 0), 0);
    add_probe(vec(CMax, CMax, CMax), vec(CMax, CMax, CMax), vec(CMin, CMin, CMin),
              1, 0, vec(CMax, CMax, CMax), 0);
    add_probe(vec(CMax, CMax, CMax), vec(CMin, CMin, CMin), vec(CMin, CMin, CMin));
    add_probe(vec(CMin, CMin, CMin), vec(CMax, CMax, CMax), vec(CMax, CMax, CMax));
    add_probe(vec(CMax, CMin, 0), vec(CMin, CMax, -1), vec(CMin, CMax, 0));
    add_probe(vec(100, -100, 50), vec(-200, -300, -400), vec(500, 600, 700));
    add_probe(vec(-1, -1, -1), vec(-2, -3, -4), vec(1, 2, 3));
    add_probe(vec(CMin, CMax, 1), vec(-1, 0, CMax), vec(1, -1, CMin));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probe_rows[i]) begin
      want = probe_rows[i].typed ? probe_rows[i].want : nearest_corner(probe_rows[i].q);
      send_word(probe_rows[i].q, want, $urandom_range(0, 6));
    end
    settle();

    for (int i = 0; i < 1150; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == 700) settle();
      q = random_query();
      gap = ((i / 100) % 3 == 0) ? 0 : $urandom_range(0, 6);
      send_word(q, nearest_corner(q), gap);
    end
    settle();
    repeat (Latency + 10) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : drain
    corner_hit_t got;
    corner_hit_t want;
    int          stall;
    int          taken;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = ((taken / 128) % 3 == 0) ? 0 : $urandom_range(0, 6);
      if (hold_off) begin
        stall = HoldCycles;
        hold_off = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      got.idx = out_corner_index;
      got.corner = vec(out_corner_x, out_corner_y, out_corner_z);
      got.span = out_distance;
      if (expected_hits.size() == 0) begin
        report_mismatch("word with nothing pending, corner_index", got.idx, -1);
      end else begin
        want = expected_hits.pop_front();
        if (got.idx !== want.idx) report_mismatch("corner_index", got.idx, want.idx);
        for (int a = 0; a < 3; a++)
          if (got.corner[a] !== want.corner[a])
            report_mismatch(axis_field[a], $signed(got.corner[a]), $signed(want.corner[a]));
        if (got.span !== want.span) report_mismatch("distance", got.span, want.span);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
